@@ rtl/sea_pkg.sv @@
// Shared types and constants for the ascending sort engine.
// Used by sea_cell and sort_engine_ascending_top; no dependencies.
package sea_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned MaxItemsDflt = 64;

  typedef logic signed [DataW-1:0] data_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic  valid;
    logic  gt;      // held value sorts after the word being inserted (or cell is empty)
    data_t value;
  } cell_t;

  // Chain-wide control, same for every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } ctrl_t;

endpackage

@@ rtl/sea_cell.sv @@
// One cell of the insertion chain: holds one element and its valid bit.
// Depends on sea_pkg.
module sea_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sea_pkg::ctrl_t ctrl_i,
  input  sea_pkg::data_t ins_value_i,
  input  sea_pkg::cell_t left_i,
  input  sea_pkg::cell_t right_i,
  output sea_pkg::cell_t cell_o
);
  import sea_pkg::*;

  logic  valid_q, valid_d;
  data_t value_q, value_d;
  logic  gt;

  // Empty cells count as greater so the new word lands at the end of the run.
  assign gt = !valid_q || (ins_value_i < value_q);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      // Drain: move toward the output end.
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (ctrl_i.insert) begin
      valid_d = valid_q | left_i.valid;
      if (left_i.gt) begin
        value_d = left_i.value;
      end else if (gt) begin
        value_d = ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, gt: gt, value: value_q};

endmodule

@@ rtl/sort_engine_ascending_top.sv @@
// Top level of the ascending sort engine: a systolic insertion chain.
// Depends on sea_pkg and sea_cell.
//
// Usage:
//  - Input channel (s_axis): one signed 32-bit word per beat, tlast on the
//    final word of a run. Each word is placed into the sorted chain in the
//    cycle it is accepted.
//  - Output channel (m_axis): after the word carrying tlast, the held words
//    come out in ascending signed order, one per cycle while tready is high,
//    tlast on the final one. The first result is valid the cycle after the
//    last input word is accepted.
//  - Throughput: one word per cycle in, one per cycle out while tready is
//    high. The input is closed while the chain drains, because the drain
//    shifts every cell toward the output.
//  - Capacity: MAX_ITEMS cells. Once they are all full, further words of the
//    run (tlast word included) are accepted and dropped; the run still ends.
//  - Stall: if m_axis_tready_i is low, the chain holds and the head word
//    stays on m_axis_tdata_o.
//  - Reset: clears all valid bits and the drain flag; the block comes up
//    empty and ready for a new run.
module sort_engine_ascending_top #(
  parameter int unsigned MAX_ITEMS = sea_pkg::MaxItemsDflt
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [sea_pkg::DataW-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                     s_axis_tlast_i,  // last
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [sea_pkg::DataW-1:0] m_axis_tdata_o,  // [31:0] sorted_value
  output logic                     m_axis_tlast_o   // last_out
);
  import sea_pkg::*;

  logic          drain_q, drain_d;
  logic          in_acc, out_acc, full;
  ctrl_t         ctrl;
  cell_t         cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid_vec;

  // The cell at the tail end being valid means every cell holds a word.
  assign full = cells[MAX_ITEMS-1].valid;

  assign s_axis_tready_o = !drain_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Head cell is always valid while draining; it drives the output.
  assign m_axis_tvalid_o = drain_q;
  assign m_axis_tdata_o  = cells[0].value;
  assign m_axis_tlast_o  = !cells[1].valid;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  // Drop the word when the chain is full; advance the chain on each output beat.
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  always_comb begin
    drain_d = drain_q;
    if (in_acc && s_axis_tlast_i) begin
      drain_d = 1'b1;
    end else if (out_acc && m_axis_tlast_o) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
    end else begin
      drain_q <= drain_d;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t left_w, right_w;

    if (i == 0) begin : g_head
      // Virtual neighbor ahead of the head: always valid, never greater.
      assign left_w = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_mid_l
      assign left_w = cells[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_w = '{valid: 1'b0, gt: 1'b1, value: '0};
    end else begin : g_mid_r
      assign right_w = cells[i+1];
    end

    sea_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .ins_value_i(data_t'(s_axis_tdata_i)),
      .left_i     (left_w),
      .right_i    (right_w),
      .cell_o     (cells[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

`ifndef SYNTHESIS
  // Occupied cells always form a contiguous block from the head.
  a_valid_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{MAX_ITEMS{1'b0}}, 1'b1}))
    else $error("valid bits not contiguous from head");

  // Draining never begins or continues with an empty head.
  a_drain_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> cells[0].valid)
    else $error("draining with empty head cell");

  // The end of a run opens the output on the next cycle.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (m_axis_tvalid_o && !s_axis_tready_o))
    else $error("run end did not start drain");

  // The final result leaves the chain empty and reopens the input.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> (s_axis_tready_o && (valid_vec == '0)))
    else $error("chain not empty after final result");
`endif

endmodule
